// ----- rtl/dqr_pkg.sv -----
// Shared types and constants for the DNS query responder.
// Used by the CSR block, controller, datapath and top level.
package dqr_pkg;

   localparam int NAME_MAX_LEN  = 128;
   localparam int MAX_QUESTIONS = 16;
   localparam int REQ_MAX_LEN   = 128;
   localparam int HDR_BYTES     = 12;
   localparam int TAIL_BYTES    = 4;
   localparam int ANSWER_BYTES  = 16;

   localparam int CNT_W  = $clog2(REQ_MAX_LEN + 1);
   localparam int QI_W   = $clog2(MAX_QUESTIONS + 1);
   localparam int QA_W   = (MAX_QUESTIONS > 1) ? $clog2(MAX_QUESTIONS) : 1;
   localparam int NL_W   = $clog2(NAME_MAX_LEN + 1);
   localparam int SUM_W  = NL_W + 2;
   localparam int TOT_W  = CNT_W + QI_W + 4;
   localparam int HA_W   = $clog2(HDR_BYTES);
   localparam int IDX_W  = (QI_W > HA_W) ? QI_W : HA_W;
   localparam int RML_W  = 13;

   localparam logic [15:0] PTR_MARK     = 16'hC000;
   localparam logic [7:0]  HDR_OPC_BITS = 8'h78;
   localparam logic [7:0]  QR_BIT       = 8'h80;
   localparam logic [15:0] TYPE_A       = 16'd1;
   localparam logic [2:0]  ADDR_LEN_A   = 3'd4;

   localparam logic [1:0] KIND_ECHO   = 2'd0;
   localparam logic [1:0] KIND_ANSWER = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_DROP   = 2'd3;

   typedef enum logic [1:0] {
      REG_ANSWER_IP     = 2'd0,
      REG_TTL_SECONDS   = 2'd1,
      REG_REPLY_MAX_LEN = 2'd2
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_HDR  = 6'b000010,
      ST_ECHO = 6'b000100,
      ST_LCHK = 6'b001000,
      ST_ANS  = 6'b010000,
      ST_STAT = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LEN    = 3'd1,
      PH_LABEL  = 3'd2,
      PH_TAIL   = 3'd3,
      PH_TRAIL  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      SEL_HDR  = 2'd0,
      SEL_ECHO = 2'd1,
      SEL_ANS  = 2'd2,
      SEL_STAT = 2'd3
   } out_sel_type;

   typedef struct packed {
      logic [31:0]      answer_ip;
      logic [31:0]      ttl_seconds;
      logic [RML_W-1:0] reply_max_len;
   } cfg_type;

   typedef struct packed {
      logic        accept;
      logic        idx_clr;
      logic        idx_inc;
      logic        clear;
      out_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic hdr;
      logic echo;
      logic last_in;
      logic last_held;
      logic fail;
      logic has_q;
      logic hdr_end;
      logic ans_end;
   } status_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] answer_pointer;
      logic [15:0] answer_type;
      logic [15:0] answer_class;
      logic [31:0] answer_ttl;
      logic [2:0]  answer_addr_len;
      logic [31:0] answer_address;
      logic [15:0] reply_length;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/dqr_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on dqr_pkg.
module dqr_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output dqr_pkg::cfg_type cfg
);
   import dqr_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ANSWER_IP:     cfg_in.answer_ip     = csr_pwdata;
            REG_TTL_SECONDS:   cfg_in.ttl_seconds   = csr_pwdata;
            REG_REPLY_MAX_LEN: cfg_in.reply_max_len = csr_pwdata[RML_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ANSWER_IP:     csr_prdata = cfg_ff.answer_ip;
         REG_TTL_SECONDS:   csr_prdata = cfg_ff.ttl_seconds;
         REG_REPLY_MAX_LEN: csr_prdata = {{(32-RML_W){1'b0}}, cfg_ff.reply_max_len};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.answer_ip     <= 32'd3232236545;
         cfg_ff.ttl_seconds   <= 32'd300;
         cfg_ff.reply_max_len <= RML_W'(512);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/dqr_ctrl.sv -----
// Controller state machine: request intake and result sequencing.
// Depends on dqr_pkg; drives the datapath through cmd_type.
module dqr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  dqr_pkg::status_type status,
   output dqr_pkg::cmd_type    cmd
);
   import dqr_pkg::*;

   state_type state_ff, state_in;
   logic      take;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_HDR) || (state_ff == ST_ECHO) ||
                       (state_ff == ST_ANS) || (state_ff == ST_STAT);
   assign take       = rsp_tvalid & rsp_tready;

   always_comb begin
      state_in    = state_ff;
      cmd.accept  = req_tvalid & req_tready;
      cmd.idx_clr = 1'b0;
      cmd.idx_inc = 1'b0;
      cmd.clear   = 1'b0;
      cmd.sel     = SEL_ECHO;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) begin
               if (status.hdr)          state_in = ST_HDR;
               else if (status.echo)    state_in = ST_ECHO;
               else if (status.last_in) state_in = ST_LCHK;
            end
         end
         ST_HDR: begin
            cmd.sel = SEL_HDR;
            if (take) begin
               if (status.hdr_end) state_in = status.last_held ? ST_LCHK : ST_IDLE;
               else                cmd.idx_inc = 1'b1;
            end
         end
         ST_ECHO: begin
            cmd.sel = SEL_ECHO;
            if (take) state_in = status.last_held ? ST_LCHK : ST_IDLE;
         end
         ST_LCHK: begin
            cmd.idx_clr = 1'b1;
            state_in    = (!status.fail && status.has_q) ? ST_ANS : ST_STAT;
         end
         ST_ANS: begin
            cmd.sel = SEL_ANS;
            if (take) begin
               if (status.ans_end) state_in = ST_STAT;
               else                cmd.idx_inc = 1'b1;
            end
         end
         ST_STAT: begin
            cmd.sel = SEL_STAT;
            if (take) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a result is pending");

   a_stat_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STAT && rsp_tready) |=> req_tready)
      else $error("status taken but intake not reopened");

   a_ans_has_q: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ANS) |-> (status.has_q && !status.fail))
      else $error("answer emitted without questions or after a failure");

   a_hdr_after_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && status.hdr) |=> (state_ff == ST_HDR))
      else $error("header completion did not start header output");

endmodule

// ----- rtl/dqr_datapath.sv -----
// Datapath: header hold, question walker, question stores and result fields.
// Depends on dqr_pkg; commanded by dqr_ctrl.
module dqr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_byte,
   input  logic                req_last,
   input  dqr_pkg::cfg_type    cfg,
   input  dqr_pkg::cmd_type    cmd,
   output dqr_pkg::status_type status,
   output dqr_pkg::rsp_type    rsp
);
   import dqr_pkg::*;

   logic [7:0]       hold_ff [HDR_BYTES];
   logic [CNT_W-1:0] off_ff  [MAX_QUESTIONS];
   logic [15:0]      type_ff [MAX_QUESTIONS];
   logic [15:0]      class_ff[MAX_QUESTIONS];

   logic [CNT_W-1:0] count_ff, count_in;
   logic [QI_W-1:0]  qt_ff, qt_in;
   logic [QI_W-1:0]  qi_ff, qi_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       ll_ff, ll_in;
   logic [NL_W-1:0]  nl_ff, nl_in;
   logic [31:0]      cap_ff, cap_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       echo_ff;
   logic             last_ff;

   logic             hold_we, hdr_fix, q_we, off_we;
   logic [HA_W-1:0]  hold_wa;
   logic [QA_W-1:0]  q_wa, off_wa;
   logic [CNT_W-1:0] off_wd;
   logic [31:0]      cap_new;
   logic [15:0]      qd;
   logic [SUM_W-1:0] name_sum;
   logic [QI_W-1:0]  qi_next;
   logic             body_drop, st_hdr, st_echo;
   logic [TOT_W-1:0] total;
   logic [QA_W-1:0]  ans_a;
   logic             fail;

   assign qd      = {hold_ff[4], hold_ff[5]};
   assign cap_new = {cap_ff[23:0], req_byte};
   assign qi_next = qi_ff + 1'b1;
   assign name_sum = SUM_W'(nl_ff) + SUM_W'(req_byte) + 1'b1;

   always_comb begin
      count_in  = count_ff;
      qt_in     = qt_ff;
      qi_in     = qi_ff;
      phase_in  = phase_ff;
      ll_in     = ll_ff;
      nl_in     = nl_ff;
      cap_in    = cap_ff;
      drop_in   = drop_ff;
      hold_we   = 1'b0;
      hold_wa   = count_ff[HA_W-1:0];
      hdr_fix   = 1'b0;
      q_we      = 1'b0;
      q_wa      = qi_ff[QA_W-1:0];
      off_we    = 1'b0;
      off_wa    = qi_next[QA_W-1:0];
      off_wd    = count_ff + 1'b1;
      body_drop = 1'b0;
      st_hdr    = 1'b0;
      st_echo   = 1'b0;
      if (cmd.clear) begin
         count_in = '0;
         qt_in    = '0;
         qi_in    = '0;
         phase_in = PH_HEADER;
         ll_in    = '0;
         nl_in    = '0;
         cap_in   = '0;
         drop_in  = 1'b0;
      end else if (cmd.accept && !drop_ff) begin
         if (count_ff >= CNT_W'(REQ_MAX_LEN)) begin
            drop_in = 1'b1;
         end else if (phase_ff == PH_HEADER) begin
            hold_we  = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(HDR_BYTES - 1)) begin
               if ((hold_ff[2] & HDR_OPC_BITS) != 8'd0 || qd > 16'(MAX_QUESTIONS)) begin
                  drop_in = 1'b1;
               end else begin
                  hdr_fix  = 1'b1;
                  st_hdr   = 1'b1;
                  qt_in    = qd[QI_W-1:0];
                  qi_in    = '0;
                  nl_in    = '0;
                  phase_in = (qd == 16'd0) ? PH_TRAIL : PH_LEN;
                  off_we   = 1'b1;
                  off_wa   = '0;
                  off_wd   = CNT_W'(HDR_BYTES);
               end
            end
         end else begin
            case (phase_ff)
               PH_LEN: begin
                  if (req_byte == 8'd0) begin
                     cap_in   = '0;
                     ll_in    = 8'(TAIL_BYTES);
                     phase_in = PH_TAIL;
                  end else if (name_sum > SUM_W'(NAME_MAX_LEN)) begin
                     body_drop = 1'b1;
                  end else begin
                     nl_in    = name_sum[NL_W-1:0];
                     ll_in    = req_byte;
                     phase_in = PH_LABEL;
                  end
               end
               PH_LABEL: begin
                  ll_in = ll_ff - 1'b1;
                  if (ll_ff == 8'd1) phase_in = PH_LEN;
               end
               PH_TAIL: begin
                  cap_in = cap_new;
                  ll_in  = ll_ff - 1'b1;
                  if (ll_ff == 8'd1) begin
                     q_we  = 1'b1;
                     qi_in = qi_next;
                     if (qi_next >= qt_ff) begin
                        phase_in = PH_TRAIL;
                     end else begin
                        off_we   = 1'b1;
                        nl_in    = '0;
                        phase_in = PH_LEN;
                     end
                  end
               end
               default: ;
            endcase
            if (body_drop) begin
               drop_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               st_echo  = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (cmd.accept || cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc)          idx_in = idx_ff + 1'b1;
      else                           idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         qt_ff    <= '0;
         qi_ff    <= '0;
         phase_ff <= PH_HEADER;
         ll_ff    <= '0;
         nl_ff    <= '0;
         cap_ff   <= '0;
         drop_ff  <= 1'b0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         qt_ff    <= qt_in;
         qi_ff    <= qi_in;
         phase_ff <= phase_in;
         ll_ff    <= ll_in;
         nl_ff    <= nl_in;
         cap_ff   <= cap_in;
         drop_ff  <= drop_in;
         idx_ff   <= idx_in;
         if (cmd.accept) last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) echo_ff <= req_byte;
      if (hold_we) hold_ff[hold_wa] <= req_byte;
      if (hdr_fix) begin
         hold_ff[2] <= hold_ff[2] | QR_BIT;
         hold_ff[6] <= hold_ff[4];
         hold_ff[7] <= hold_ff[5];
      end
      if (off_we) off_ff[off_wa] <= off_wd;
      if (q_we) begin
         type_ff[q_wa]  <= cap_new[31:16];
         class_ff[q_wa] <= cap_new[15:0];
      end
   end

   assign total = TOT_W'(count_ff) + TOT_W'({qt_ff, 4'b0000});
   assign fail  = drop_ff || (phase_ff != PH_TRAIL) ||
                  (total > TOT_W'(cfg.reply_max_len));
   assign ans_a = idx_ff[QA_W-1:0];

   assign status.hdr       = st_hdr;
   assign status.echo      = st_echo;
   assign status.last_in   = req_last;
   assign status.last_held = last_ff;
   assign status.fail      = fail;
   assign status.has_q     = (qt_ff != '0);
   assign status.hdr_end   = (idx_ff == IDX_W'(HDR_BYTES - 1));
   assign status.ans_end   = (idx_ff == IDX_W'(qt_ff - 1'b1));

   always_comb begin
      rsp = '0;
      case (cmd.sel)
         SEL_HDR: begin
            rsp.kind      = KIND_ECHO;
            rsp.data_byte = hold_ff[idx_ff[HA_W-1:0]];
         end
         SEL_ECHO: begin
            rsp.kind      = KIND_ECHO;
            rsp.data_byte = echo_ff;
         end
         SEL_ANS: begin
            rsp.kind = KIND_ANSWER;
            if (type_ff[ans_a] == TYPE_A) begin
               rsp.answer_pointer  = PTR_MARK | 16'(off_ff[ans_a]);
               rsp.answer_type     = type_ff[ans_a];
               rsp.answer_class    = class_ff[ans_a];
               rsp.answer_ttl      = cfg.ttl_seconds;
               rsp.answer_addr_len = ADDR_LEN_A;
               rsp.answer_address  = cfg.answer_ip;
            end
         end
         SEL_STAT: begin
            rsp.last = 1'b1;
            if (fail) begin
               rsp.kind = KIND_DROP;
            end else begin
               rsp.kind         = KIND_DONE;
               rsp.reply_length = 16'(total);
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/dns_query_responder.sv -----
// DNS query responder top level. Header bytes and bytes after a drop are taken back to back;
// any other byte is accepted and then echoed before the next is taken; rsp_tready can stall.
// The byte that completes the header gives 12 results, one per cycle barring rsp_tready stalls;
// the last byte leads to a check state, then one answer per question (up to 16) unless the
// request failed, and a status. No byte is taken while results are pending.
// Synchronous reset clears control state and loads register defaults.
module dns_query_responder (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] req_byte
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [7:0] data_byte, [23:8] answer_pointer, [39:24] answer_type,
   // [55:40] answer_class, [87:56] answer_ttl, [90:88] answer_addr_len,
   // [122:91] answer_address, [138:123] reply_length, [143:139] zero
   output logic [143:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,   // [1:0] kind
   output logic          rsp_tlast,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import dqr_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   rsp_type    rsp;

   dqr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dqr_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_byte (req_tdata),
      .req_last (req_tlast),
      .cfg      (cfg),
      .cmd      (cmd),
      .status   (status),
      .rsp      (rsp)
   );

   assign rsp_tdata = {5'b00000, rsp.reply_length, rsp.answer_address, rsp.answer_addr_len,
                       rsp.answer_ttl, rsp.answer_class, rsp.answer_type,
                       rsp.answer_pointer, rsp.data_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule
